### src/srma_pkg.sv
package srma_pkg;

    localparam int ROWS   = 16;
    localparam int SLOTS  = 64;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int ADDR_W = ROW_W + SLOT_W;
    localparam logic [15:0] ADD_MAX = 16'hFFFF;

    typedef struct packed {
        logic [3:0]         row;
        logic [15:0]        feat_index;
        logic signed [31:0] feat_value;
        logic               last;
    } item_t;

    typedef struct packed {
        logic [15:0]        out_index;
        logic signed [31:0] out_value;
        logic [15:0]        adds_done;
        logic               overflowed;
        logic               out_last;
    } result_t;

    typedef struct packed {
        logic [15:0]        idx;
        logic signed [31:0] val;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic init;
        logic mrd;
        logic mwr;
        logic upd;
        logic erd;
        logic eld;
        logic oack;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic merge_done;
        logic emit_done;
    } stat_t;

    // Signed add that clamps to the 32-bit range.
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] x,
                                                   input logic signed [31:0] y);
        logic signed [32:0] s;
        s = {x[31], x} + {y[31], y};
        if (s[32] != s[31])
        begin
            sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            sat_add = s[31:0];
        end
    endfunction

endpackage

### src/srma_ctrl.sv
module srma_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  logic           item_last,
    input  logic           result_stall,
    input  srma_pkg::stat_t stat,
    output logic           item_stall,
    output srma_pkg::cmd_t cmd
);
    import srma_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_MRD  = 3'd2;
    localparam logic [2:0] S_MWR  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_ERD  = 3'd5;
    localparam logic [2:0] S_ELD  = 3'd6;
    localparam logic [2:0] S_EWT  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.load = 1'b1;
                    if (item_last)
                    begin
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = S_MRD;
            end
            S_MRD:
            begin
                if (stat.merge_done)
                begin
                    state_next = S_UPD;
                end
                else
                begin
                    cmd.mrd    = 1'b1;
                    state_next = S_MWR;
                end
            end
            S_MWR:
            begin
                cmd.mwr    = 1'b1;
                state_next = S_MRD;
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = S_ERD;
            end
            S_ERD:
            begin
                cmd.erd    = 1'b1;
                state_next = S_ELD;
            end
            S_ELD:
            begin
                cmd.eld    = 1'b1;
                state_next = S_EWT;
            end
            S_EWT:
            begin
                if (!result_stall)
                begin
                    cmd.oack   = 1'b1;
                    state_next = stat.emit_done ? S_IDLE : S_ERD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### src/srma_dp.sv
module srma_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  srma_pkg::cmd_t   cmd,
    input  srma_pkg::item_t  item,
    output srma_pkg::stat_t  stat,
    output logic             result_valid,
    output srma_pkg::result_t result
);
    import srma_pkg::*;

    entry_t in_mem [SLOTS];
    entry_t m_mem [SLOTS];
    entry_t row_mem [ROWS * SLOTS];

    logic [CNT_W-1:0] row_len_reg [ROWS];
    logic [15:0]      add_cnt_reg [ROWS];

    logic [CNT_W-1:0] cnt_reg;
    logic             iovf_reg;
    logic [ROW_W-1:0] row_reg;
    logic [CNT_W-1:0] len_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] a_reg;
    logic [CNT_W-1:0] b_reg;
    logic [CNT_W-1:0] mlen_reg;
    logic [CNT_W-1:0] k_reg;
    logic [15:0]      adds_reg;
    entry_t           ra_reg;
    entry_t           rb_reg;
    entry_t           rm_reg;
    logic             out_valid_reg;
    result_t          out_reg;

    logic   has_a;
    logic   has_b;
    logic   take_a;
    logic   take_b;
    entry_t pick;
    logic [15:0] adds_next;

    assign has_a = (a_reg < len_reg);
    assign has_b = (b_reg < cnt_reg);
    assign stat.merge_done = !has_a && !has_b;
    assign stat.emit_done  = (k_reg == mlen_reg);
    assign result_valid    = out_valid_reg;
    assign result          = out_reg;
    assign adds_next = (add_cnt_reg[row_reg] == ADD_MAX) ? ADD_MAX
                                                         : add_cnt_reg[row_reg] + 16'd1;

    // Pick the next merged entry from the two list heads.
    always_comb
    begin
        take_a = 1'b0;
        take_b = 1'b0;
        pick   = rb_reg;
        if (has_a && has_b)
        begin
            if (ra_reg.idx == rb_reg.idx)
            begin
                take_a   = 1'b1;
                take_b   = 1'b1;
                pick.idx = rb_reg.idx;
                pick.val = sat_add(ra_reg.val, rb_reg.val);
            end
            else if (ra_reg.idx > rb_reg.idx)
            begin
                take_b = 1'b1;
            end
            else
            begin
                take_a = 1'b1;
                pick   = ra_reg;
            end
        end
        else if (has_b)
        begin
            take_b = 1'b1;
        end
        else
        begin
            take_a = 1'b1;
            pick   = ra_reg;
        end
    end

    // Incoming buffer memory.
    always_ff @(posedge clk)
    begin
        if (cmd.load && (cnt_reg < CNT_W'(SLOTS)))
        begin
            in_mem[cnt_reg[SLOT_W-1:0]] <= '{idx: item.feat_index, val: item.feat_value};
        end
        if (cmd.mrd)
        begin
            rb_reg <= in_mem[b_reg[SLOT_W-1:0]];
        end
    end

    // Stored row memory: read during the merge, rewritten during emission.
    always_ff @(posedge clk)
    begin
        if (cmd.eld)
        begin
            row_mem[{row_reg, k_reg[SLOT_W-1:0]}] <= rm_reg;
        end
        if (cmd.mrd)
        begin
            ra_reg <= row_mem[{row_reg, a_reg[SLOT_W-1:0]}];
        end
    end

    // Merge result memory.
    always_ff @(posedge clk)
    begin
        if (cmd.mwr && (mlen_reg < CNT_W'(SLOTS)))
        begin
            m_mem[mlen_reg[SLOT_W-1:0]] <= pick;
        end
        if (cmd.erd)
        begin
            rm_reg <= m_mem[k_reg[SLOT_W-1:0]];
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (cmd.eld)
        begin
            out_reg.out_index  <= rm_reg.idx;
            out_reg.out_value  <= rm_reg.val;
            out_reg.adds_done  <= adds_reg;
            out_reg.overflowed <= ovf_reg;
            out_reg.out_last   <= (k_reg + CNT_W'(1) == mlen_reg);
        end
    end

    // Counters, per-row bookkeeping and handshake state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_len_reg   <= '{default: '0};
            add_cnt_reg   <= '{default: '0};
            cnt_reg       <= '0;
            iovf_reg      <= 1'b0;
            row_reg       <= '0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            mlen_reg      <= '0;
            k_reg         <= '0;
            adds_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (cnt_reg < CNT_W'(SLOTS))
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                else
                begin
                    iovf_reg <= 1'b1;
                end
                if (item.last)
                begin
                    row_reg <= item.row[ROW_W-1:0];
                end
            end
            if (cmd.init)
            begin
                len_reg  <= (add_cnt_reg[row_reg] == 16'd0) ? '0 : row_len_reg[row_reg];
                ovf_reg  <= iovf_reg;
                a_reg    <= '0;
                b_reg    <= '0;
                mlen_reg <= '0;
            end
            if (cmd.mwr)
            begin
                if (take_a)
                begin
                    a_reg <= a_reg + CNT_W'(1);
                end
                if (take_b)
                begin
                    b_reg <= b_reg + CNT_W'(1);
                end
                if (mlen_reg < CNT_W'(SLOTS))
                begin
                    mlen_reg <= mlen_reg + CNT_W'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.upd)
            begin
                row_len_reg[row_reg] <= mlen_reg;
                add_cnt_reg[row_reg] <= adds_next;
                adds_reg             <= adds_next;
                cnt_reg              <= '0;
                iovf_reg             <= 1'b0;
                k_reg                <= '0;
            end
            if (cmd.eld)
            begin
                k_reg         <= k_reg + CNT_W'(1);
                out_valid_reg <= 1'b1;
            end
            if (cmd.oack)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The buffer and the merged row never grow past their capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(SLOTS) && mlen_reg <= CNT_W'(SLOTS))
        else $error("srma_dp: count beyond capacity");

    // Emission never runs past the merged length.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eld |-> (k_reg < mlen_reg))
        else $error("srma_dp: emission past merged length");

    // A new result is never loaded over one that is still pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eld |-> !out_valid_reg)
        else $error("srma_dp: result overwritten");

    // The buffer is cleared once a vector has been merged.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd |=> (cnt_reg == '0 && !iovf_reg))
        else $error("srma_dp: buffer not cleared");

endmodule

### src/sparse_row_merge_add_top.sv
// Sparse row merge-add. Items stream one sparse vector's elements into an
// incoming buffer at one transaction per cycle; the item with last set picks
// the row and starts the merge. An empty row takes the vector as is, otherwise
// equal indices add with saturation and the rest interleave by index. The
// merge alternates a read of each list head with a compare and write, once
// per merged entry, since the row and buffer memories have registered reads.
// The merged row is then sent out, one result transaction per entry, each
// held until it is taken before the next entry is read, while each entry is
// written back into the row memory. No item is accepted from the last item
// of a vector until its last result is taken.
module sparse_row_merge_add_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  srma_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output srma_pkg::result_t result
);
    import srma_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    srma_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_last    (item.last),
        .result_stall (result_stall),
        .stat         (stat),
        .item_stall   (item_stall),
        .cmd          (cmd)
    );

    srma_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item         (item),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import srma_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    sparse_row_merge_add_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Mirror of the block's row table and incoming vector buffer.
    logic [15:0]        row_idx_m [ROWS][SLOTS];
    logic signed [31:0] row_val_m [ROWS][SLOTS];
    int unsigned        row_len_m [ROWS];
    logic [15:0]        row_adds_m [ROWS];
    logic [15:0]        buf_idx_m [SLOTS];
    logic signed [31:0] buf_val_m [SLOTS];
    int unsigned        buf_cnt_m;
    logic               buf_ovf_m;

    item_t   pending_items [$];
    result_t merged_entries [$];
    int      mismatches;
    int      results_seen;
    int      items_sent;
    int      vectors_sent;
    int      idle_cycles;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Clamped signed sum of two Q16.16 values.
    function automatic logic signed [31:0] clamp_sum(input logic signed [31:0] x,
                                                     input logic signed [31:0] y);
        longint s;
        s = longint'(x) + longint'(y);
        if (s > 64'sd2147483647)
        begin
            s = 64'sd2147483647;
        end
        if (s < -64'sd2147483648)
        begin
            s = -64'sd2147483648;
        end
        return s[31:0];
    endfunction

    // Buffer one element; on the closing element merge into the row and queue results.
    task automatic predict_merge(input item_t it);
        logic [15:0]        m_idx [SLOTS];
        logic signed [31:0] m_val [SLOTS];
        int unsigned        mlen;
        int unsigned        a;
        int unsigned        b;
        int unsigned        r;
        int unsigned        len;
        logic               ovf;
        logic [15:0]        ti;
        logic signed [31:0] tv;
        result_t            res;
        mlen = 0;
        a = 0;
        b = 0;
        if (buf_cnt_m < SLOTS)
        begin
            buf_idx_m[buf_cnt_m] = it.feat_index;
            buf_val_m[buf_cnt_m] = it.feat_value;
            buf_cnt_m++;
        end
        else
        begin
            buf_ovf_m = 1'b1;
        end
        if (!it.last)
        begin
            return;
        end
        r = it.row % ROWS;
        ovf = buf_ovf_m;
        len = row_len_m[r];
        if (row_adds_m[r] == 0)
        begin
            for (int k = 0; k < buf_cnt_m; k++)
            begin
                m_idx[k] = buf_idx_m[k];
                m_val[k] = buf_val_m[k];
            end
            mlen = buf_cnt_m;
        end
        else
        begin
            while (a < len || b < buf_cnt_m)
            begin
                if (a < len && b < buf_cnt_m && row_idx_m[r][a] == buf_idx_m[b])
                begin
                    ti = buf_idx_m[b];
                    tv = clamp_sum(row_val_m[r][a], buf_val_m[b]);
                    a++;
                    b++;
                end
                else if (b < buf_cnt_m && (a >= len || row_idx_m[r][a] > buf_idx_m[b]))
                begin
                    ti = buf_idx_m[b];
                    tv = buf_val_m[b];
                    b++;
                end
                else
                begin
                    ti = row_idx_m[r][a];
                    tv = row_val_m[r][a];
                    a++;
                end
                if (mlen < SLOTS)
                begin
                    m_idx[mlen] = ti;
                    m_val[mlen] = tv;
                    mlen++;
                end
                else
                begin
                    ovf = 1'b1;
                end
            end
        end
        for (int k = 0; k < mlen; k++)
        begin
            row_idx_m[r][k] = m_idx[k];
            row_val_m[r][k] = m_val[k];
        end
        row_len_m[r] = mlen;
        if (row_adds_m[r] != ADD_MAX)
        begin
            row_adds_m[r]++;
        end
        buf_cnt_m = 0;
        buf_ovf_m = 1'b0;
        for (int k = 0; k < mlen; k++)
        begin
            res.out_index  = m_idx[k];
            res.out_value  = m_val[k];
            res.adds_done  = row_adds_m[r];
            res.overflowed = ovf;
            res.out_last   = (k + 1 == mlen);
            merged_entries = {merged_entries, res};
        end
    endtask

    // Random gap length: mostly zero or short, sometimes long.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
        begin
            return 0;
        end
        else if (p < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Queue one vector with ascending random indices.
    task automatic add_vector(input int n, input logic [3:0] r, input int unsigned span);
        item_t it;
        int unsigned ix;
        ix = $urandom_range(0, span);
        for (int k = 0; k < n; k++)
        begin
            it.row        = (k == n - 1) ? r : 4'($urandom);
            it.feat_index = 16'(ix);
            it.feat_value = ($urandom_range(0, 9) == 0) ? 32'sh7FFF_FFF0 : $signed($urandom);
            it.last       = (k == n - 1);
            pending_items = {pending_items, it};
            ix = ix + $urandom_range(1, span + 1);
        end
    endtask

    // Queue one raw item.
    task automatic add_item(input logic [3:0] r, input logic [15:0] ix,
                            input logic signed [31:0] v, input logic l);
        item_t it;
        it.row = r;
        it.feat_index = ix;
        it.feat_value = v;
        it.last = l;
        pending_items = {pending_items, it};
    endtask

    // Stimulus: directed cases, then random vectors.
    initial
    begin
        int n;
        for (int r = 0; r < ROWS; r++)
        begin
            row_len_m[r] = 0;
            row_adds_m[r] = 0;
        end
        buf_cnt_m = 0;
        buf_ovf_m = 1'b0;
        // Empty row takes a vector as is, even descending.
        add_item(4'd0, 16'hFFFF, 32'sh7FFF_FFFF, 1'b0);
        add_item(4'd0, 16'h0000, -32'sh8000_0000, 1'b1);
        // Equal indices saturate at the positive end, and descending order merges.
        add_item(4'd15, 16'h0000, 32'sh7FFF_FFFF, 1'b0);
        add_item(4'd0, 16'h0001, 32'sh0000_0001, 1'b0);
        add_item(4'd0, 16'hFFFF, 32'sh7FFF_FFFF, 1'b1);
        add_item(4'd0, 16'h0000, -32'sh8000_0000, 1'b1);
        // Single element to the top row, then an interleaving add.
        add_item(4'd15, 16'h8000, 32'sh0001_0000, 1'b1);
        add_item(4'd15, 16'h0010, -32'sh0001_0000, 1'b0);
        add_item(4'd15, 16'h8000, 32'sh0000_8000, 1'b0);
        add_item(4'd15, 16'hAAAA, 32'sh5555_5555, 1'b1);
        // Buffer overflow: more than SLOTS elements in one vector.
        add_vector(SLOTS + 3, 4'd3, 2);
        // Row capacity exceeded: new indices merged into a full row.
        add_vector(4, 4'd3, 4000);
        n = 0;
        while (n < 29)
        begin
            int len;
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 24)
                                                 : $urandom_range(1, 8);
            add_vector(len, 4'($urandom_range(0, 15)), $urandom_range(0, 3) == 0 ? 4000 : 6);
            n += len;
        end
    end

    // Driver: feeds queued items with random gaps and one drain pause.
    int  gap_left;
    logic drained_once;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid   <= 1'b0;
            item         <= '0;
            gap_left     <= 0;
            drained_once <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                predict_merge(item);
                items_sent++;
                if (item.last)
                begin
                    vectors_sent++;
                end
            end
            if (!(item_valid && item_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    item_valid <= 1'b0;
                end
                else if (!drained_once && vectors_sent == 8 && merged_entries.size() != 0)
                begin
                    item_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    if (vectors_sent == 8)
                    begin
                        drained_once <= 1'b1;
                    end
                    item       <= pending_items.pop_front();
                    item_valid <= 1'b1;
                    gap_left   <= gap_len();
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random stalls and field-by-field comparison.
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (merged_entries.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected result transaction: %p", result);
                    end
                end
                else
                begin
                    want = merged_entries.pop_front();
                    if (result.out_index !== want.out_index
                        || result.out_value !== want.out_value
                        || result.adds_done !== want.adds_done
                        || result.overflowed !== want.overflowed
                        || result.out_last !== want.out_last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("result mismatch: expected %p, got %p", want, result);
                        end
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left   <= stall_left - 1;
                result_stall <= 1'b1;
            end
            else
            begin
                stall_left   <= gap_len();
                result_stall <= 1'b0;
            end
        end
    end

    // Reset, watchdog and end of run.
    initial
    begin
        mismatches   = 0;
        results_seen = 0;
        items_sent   = 0;
        vectors_sent = 0;
        idle_cycles  = 0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        while ((pending_items.size() != 0 || item_valid || merged_entries.size() != 0)
               && idle_cycles < 20000)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        if (idle_cycles >= 20000)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            repeat (400) @(posedge clk);
            $display("Sent %0d elements in %0d vectors; checked %0d merged entries.",
                     items_sent, vectors_sent, results_seen);
            if (mismatches == 0 && merged_entries.size() == 0)
            begin
                $display("TB_OK");
            end
            else
            begin
                $display("TB_ERROR");
            end
            $finish;
        end
    end

endmodule
